### design/bft_pkg.sv
// shared types, constants and character classes for the boolean formula tokenizer
package bft_pkg;

   localparam int OFFSET_W = 16;
   localparam int OUT_W = 16;
   localparam int RES_MAX = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

   typedef enum logic [3:0] {
      KIND_VAR    = 4'd0,
      KIND_CONST  = 4'd1,
      KIND_LPAREN = 4'd2,
      KIND_RPAREN = 4'd3,
      KIND_NOT    = 4'd4,
      KIND_AND    = 4'd5,
      KIND_OR     = 4'd6,
      KIND_XOR    = 4'd7,
      KIND_IMP    = 4'd8,
      KIND_IFF    = 4'd9,
      KIND_END    = 4'd10,
      KIND_ERROR  = 4'd11
   } kind_type;

   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] U8_C2     = 8'hC2;
   localparam logic [7:0] U8_AC     = 8'hAC;
   localparam logic [7:0] U8_E2     = 8'hE2;
   localparam logic [7:0] U8_88     = 8'h88;
   localparam logic [7:0] U8_8A     = 8'h8A;
   localparam logic [7:0] U8_86     = 8'h86;
   localparam logic [7:0] U8_A7     = 8'hA7;
   localparam logic [7:0] U8_A8     = 8'hA8;
   localparam logic [7:0] U8_95     = 8'h95;
   localparam logic [7:0] U8_92     = 8'h92;
   localparam logic [7:0] U8_94     = 8'h94;

   typedef struct packed {
      kind_type         kind;
      logic [OUT_W-1:0] start;
      logic [OUT_W-1:0] len;
      logic             cval;
   } res_type;

   // all results caused by one input beat, slot 0 first
   typedef struct packed {
      logic [1:0]                cnt;
      res_type [RES_MAX-1:0]     res;
   } bundle_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic ident_start(input logic [7:0] c);
      return is_alpha(c) || (c == CH_UNDER);
   endfunction

   function automatic logic ident_part(input logic [7:0] c);
      return ident_start(c) || (c >= CH_ZERO && c <= 8'h39);
   endfunction

   function automatic logic [OUT_W-1:0] off_out(input logic [OFFSET_W-1:0] x);
      return OUT_W'(x);
   endfunction

   function automatic logic [OUT_W-1:0] len_out(input logic [OFFSET_W-1:0] x);
      logic [OUT_W-1:0] r;
      if (33'(x) > 33'({OUT_W{1'b1}})) r = '1;
      else r = OUT_W'(x);
      return r;
   endfunction

endpackage

### design/bft_front.sv
// byte scanner: classifies each byte and builds the bundle of results it causes
module bft_front
   import bft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic       byte_ready,
   input  logic [7:0] byte_in,
   input  logic       final_byte,
   output logic       push,
   output bundle_type push_bundle
);

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_IDENT, MODE_LT, MODE_LTDASH, MODE_DASH, MODE_C2, MODE_E2, MODE_E2B
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [OFFSET_W-1:0]   off_ff, off_in;
   logic [OFFSET_W-1:0]   pend_ff, pend_in;
   logic [7:0]            second_ff, second_in;
   logic                  err_seen_ff, err_seen_in;

   logic [OFFSET_W-1:0]   cur, nxt, err_at;
   logic                  err, do_idle, accept;
   logic [1:0]            n;
   res_type [RES_MAX-1:0] slots;
   kind_type              k3;
   logic                  k3_ok;

   assign accept = byte_valid && byte_ready;
   assign cur = off_ff;
   assign nxt = (cur == OFFSET_MAX) ? cur : cur + 1'b1;

   always_comb begin
      k3_ok = 1'b1;
      k3 = KIND_AND;
      if (second_ff == U8_88 && byte_in == U8_A7) k3 = KIND_AND;
      else if (second_ff == U8_88 && byte_in == U8_A8) k3 = KIND_OR;
      else if (second_ff == U8_8A && byte_in == U8_95) k3 = KIND_XOR;
      else if (second_ff == U8_86 && byte_in == U8_92) k3 = KIND_IMP;
      else if (second_ff == U8_86 && byte_in == U8_94) k3 = KIND_IFF;
      else k3_ok = 1'b0;
   end

   always_comb begin
      mode_in = mode_ff;
      off_in = off_ff;
      pend_in = pend_ff;
      second_in = second_ff;
      err_seen_in = err_seen_ff;
      err = 1'b0;
      err_at = cur;
      do_idle = 1'b0;
      n = 2'd0;
      slots = '0;

      if (accept && !err_seen_ff) begin
         case (mode_ff)
            MODE_IDENT: begin
               if (!ident_part(byte_in)) begin
                  slots[n] = '{KIND_VAR, off_out(pend_ff), len_out(cur - pend_ff), 1'b0};
                  n = n + 2'd1;
                  mode_in = MODE_IDLE;
                  do_idle = 1'b1;
               end
            end
            MODE_LT: begin
               if (byte_in == CH_DASH) mode_in = MODE_LTDASH;
               else begin
                  err = 1'b1;
                  err_at = pend_ff;
               end
            end
            MODE_LTDASH: begin
               if (byte_in == CH_GT) begin
                  slots[n] = '{KIND_IFF, off_out(pend_ff), OUT_W'(3), 1'b0};
                  n = n + 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  err = 1'b1;
                  err_at = pend_ff;
               end
            end
            MODE_DASH: begin
               if (byte_in == CH_GT) begin
                  slots[n] = '{KIND_IMP, off_out(pend_ff), OUT_W'(2), 1'b0};
                  n = n + 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  err = 1'b1;
                  err_at = pend_ff;
               end
            end
            MODE_C2: begin
               if (byte_in == U8_AC) begin
                  slots[n] = '{KIND_NOT, off_out(pend_ff), OUT_W'(2), 1'b0};
                  n = n + 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  err = 1'b1;
                  err_at = pend_ff;
               end
            end
            MODE_E2: begin
               if (byte_in == U8_88 || byte_in == U8_8A || byte_in == U8_86) begin
                  second_in = byte_in;
                  mode_in = MODE_E2B;
               end else begin
                  err = 1'b1;
                  err_at = pend_ff;
               end
            end
            MODE_E2B: begin
               if (k3_ok) begin
                  slots[n] = '{k3, off_out(pend_ff), OUT_W'(3), 1'b0};
                  n = n + 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  err = 1'b1;
                  err_at = pend_ff;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         endcase

         if (do_idle && !is_space(byte_in)) begin
            if (byte_in == CH_ZERO || byte_in == CH_ONE) begin
               slots[n] = '{KIND_CONST, off_out(cur), OUT_W'(1), byte_in == CH_ONE};
               n = n + 2'd1;
            end else if (byte_in == CH_LPAREN) begin
               slots[n] = '{KIND_LPAREN, off_out(cur), OUT_W'(1), 1'b0};
               n = n + 2'd1;
            end else if (byte_in == CH_RPAREN) begin
               slots[n] = '{KIND_RPAREN, off_out(cur), OUT_W'(1), 1'b0};
               n = n + 2'd1;
            end else if (byte_in == CH_TILDE || byte_in == CH_BANG) begin
               slots[n] = '{KIND_NOT, off_out(cur), OUT_W'(1), 1'b0};
               n = n + 2'd1;
            end else if (byte_in == CH_AMP) begin
               slots[n] = '{KIND_AND, off_out(cur), OUT_W'(1), 1'b0};
               n = n + 2'd1;
            end else if (byte_in == CH_PIPE) begin
               slots[n] = '{KIND_OR, off_out(cur), OUT_W'(1), 1'b0};
               n = n + 2'd1;
            end else if (byte_in == CH_CARET) begin
               slots[n] = '{KIND_XOR, off_out(cur), OUT_W'(1), 1'b0};
               n = n + 2'd1;
            end else begin
               pend_in = cur;
               if (byte_in == CH_LT) mode_in = MODE_LT;
               else if (byte_in == CH_DASH) mode_in = MODE_DASH;
               else if (byte_in == U8_C2) mode_in = MODE_C2;
               else if (byte_in == U8_E2) mode_in = MODE_E2;
               else if (ident_start(byte_in)) mode_in = MODE_IDENT;
               else err = 1'b1;
            end
         end

         // end of formula: close an open identifier, reject an open operator
         if (!err && final_byte) begin
            if (mode_in == MODE_IDENT) begin
               slots[n] = '{KIND_VAR, off_out(pend_in), len_out(nxt - pend_in), 1'b0};
               n = n + 2'd1;
            end else if (mode_in != MODE_IDLE) begin
               err = 1'b1;
               err_at = pend_in;
            end
            if (!err) begin
               slots[n] = '{KIND_END, off_out(nxt), OUT_W'(0), 1'b0};
               n = n + 2'd1;
            end
         end
         if (err) begin
            slots[n] = '{KIND_ERROR, off_out(err_at), OUT_W'(0), 1'b0};
            n = n + 2'd1;
         end

         if (!final_byte) begin
            off_in = nxt;
            if (err) begin
               err_seen_in = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
      end

      if (accept && final_byte) begin
         mode_in = MODE_IDLE;
         off_in = '0;
         pend_in = '0;
         second_in = '0;
         err_seen_in = 1'b0;
      end
   end

   assign push = accept && (n != 2'd0);
   assign push_bundle = '{cnt: n, res: slots};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         off_ff <= '0;
         pend_ff <= '0;
         second_ff <= '0;
         err_seen_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         off_ff <= off_in;
         pend_ff <= pend_in;
         second_ff <= second_in;
         err_seen_ff <= err_seen_in;
      end
   end

endmodule

### design/bft_queue.sv
// short bundle queue between the scanner and the result serializer
module bft_queue
   import bft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_bundle,
   input  logic       pop,
   output logic       full,
   output logic       nonempty,
   output bundle_type head
);

   bundle_type        entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign nonempty = (cnt_ff != '0);
   assign head = entries_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && nonempty;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop) rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ff] <= push_bundle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### design/bft_back.sv
// result serializer: walks the head bundle one result per beat, as out_ready allows, into the output register
module bft_back
   import bft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       nonempty,
   input  bundle_type head,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output res_type    out_res,
   output logic       out_last
);

   logic [1:0] sel_ff, sel_in;
   logic       valid_ff, valid_in;
   res_type    res_ff, res_in;
   logic       last_ff, last_in;
   logic       load, is_last;

   assign load = nonempty && (!valid_ff || out_ready);
   assign is_last = (sel_ff == head.cnt - 2'd1);
   assign pop = load && is_last;

   always_comb begin
      sel_in = sel_ff;
      valid_in = valid_ff && !out_ready;
      res_in = res_ff;
      last_in = last_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in = head.res[sel_ff];
         last_in = is_last;
         sel_in = is_last ? 2'd0 : sel_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_res = res_ff;
   assign out_last = last_ff;

endmodule

### design/boolean_formula_tokenizer_top.sv
// top level of the streaming boolean formula tokenizer
// One source byte is taken per cycle whenever the four-entry bundle queue has room; the
// scanner classifies it in that same cycle and queues the zero to three results it causes.
// Results leave one per cycle while rsp_ready allows, from a registered output, after passing
// through the bundle queue; the results of one byte leave one by one, so the output port sets
// the sustained rate when results outnumber bytes. Offsets saturate at the top of the range.
module boolean_formula_tokenizer_top
   import bft_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_byte_in,
   input  logic              req_final_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_token_kind,
   output logic [OUT_W-1:0]  rsp_start_offset,
   output logic [OUT_W-1:0]  rsp_token_length,
   output logic              rsp_const_value,
   output logic              rsp_last_of_run
);

   logic       push, pop, full, nonempty;
   bundle_type push_bundle, head;
   res_type    out_res;

   assign req_ready = !full;

   bft_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_valid),
      .byte_ready  (req_ready),
      .byte_in     (req_byte_in),
      .final_byte  (req_final_byte),
      .push        (push),
      .push_bundle (push_bundle)
   );

   bft_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .full        (full),
      .nonempty    (nonempty),
      .head        (head)
   );

   bft_back u_back (
      .clock     (clock),
      .reset     (reset),
      .nonempty  (nonempty),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_res   (out_res),
      .out_last  (rsp_last_of_run)
   );

   assign rsp_token_kind = out_res.kind;
   assign rsp_start_offset = out_res.start;
   assign rsp_token_length = out_res.len;
   assign rsp_const_value = out_res.cval;

endmodule
